// ===== src/hcr_pkg.sv =====
// hcr_pkg: shared constants, types and helpers of the hermite cubic resampler
// no dependencies; used by every file of the block except hcr_ram
package hcr_pkg;

    localparam int SAMPLE_BITS  = 24;
    localparam int FRAC_BITS    = 16;
    localparam int MAX_CHANNELS = 8;
    localparam int HISTORY_TAPS = 3;
    localparam int MAX_OUT      = 16;
    localparam int STEP_BITS    = 20;
    localparam int CNT_BITS     = 4;
    localparam int CH_BITS      = 3;
    localparam int CFG_IDX_BITS = 4;
    localparam int CFG_BITS     = STEP_BITS;
    localparam int ROW_BITS     = SAMPLE_BITS * HISTORY_TAPS;
    // horner accumulator and product widths
    localparam int ACC_BITS     = 30;
    localparam int PROD_BITS    = ACC_BITS + FRAC_BITS + 1;

    localparam logic [STEP_BITS-1:0] PHASE_ONE = STEP_BITS'(1 << FRAC_BITS);
    localparam logic [STEP_BITS-1:0] MIN_STEP  = STEP_BITS'((1 << FRAC_BITS) / MAX_OUT);

    localparam logic [CFG_IDX_BITS-1:0] REG_STEP_RATIO    = CFG_IDX_BITS'(0);
    localparam logic [CFG_IDX_BITS-1:0] REG_BYPASS        = CFG_IDX_BITS'(1);
    localparam logic [CFG_IDX_BITS-1:0] REG_CHANNEL_COUNT = CFG_IDX_BITS'(2);

    localparam logic [STEP_BITS-1:0] RST_STEP_RATIO    = PHASE_ONE;
    localparam logic [CNT_BITS-1:0]  RST_CHANNEL_COUNT = CNT_BITS'(1);

    // control from the sequencer to the horner unit
    typedef struct packed {
        logic load;   // take new history and form coefficients
        logic start;  // evaluate the polynomial at the given phase
    } t_hrn_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_hrn_sts;

    function automatic logic [CNT_BITS-1:0] eff_channels(input logic [CNT_BITS-1:0] v);
        logic [CNT_BITS-1:0] r;
        if (v == '0) begin
            r = CNT_BITS'(1);
        end else if (v > CNT_BITS'(MAX_CHANNELS)) begin
            r = CNT_BITS'(MAX_CHANNELS);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

// ===== src/hcr_in_if.sv =====
// hcr_in_if: input sample channel, valid/ready handshake
// depends on hcr_pkg
interface hcr_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [hcr_pkg::SAMPLE_BITS-1:0] in_sample;

    modport source (output valid, output in_sample, input ready);
    modport sink   (input valid, input in_sample, output ready);
endinterface

// ===== src/hcr_out_if.sv =====
// hcr_out_if: result channel, valid/ready handshake
// depends on hcr_pkg
interface hcr_out_if;
    logic                                   valid;
    logic                                   ready;
    logic signed [hcr_pkg::SAMPLE_BITS-1:0] out_sample;
    logic [hcr_pkg::CH_BITS-1:0]            out_channel;
    logic                                   last_of_run;

    modport source (output valid, output out_sample, output out_channel,
                    output last_of_run, input ready);
    modport sink   (input valid, input out_sample, input out_channel,
                    input last_of_run, output ready);
endinterface

// ===== src/hcr_ram.sv =====
// hcr_ram: generic single write port, single read port ram with registered read
// no dependencies
module hcr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

// ===== src/hcr_horner.sv =====
// hcr_horner: catmull-rom coefficients and three-step horner evaluation on one multiplier
// depends on hcr_pkg
module hcr_horner (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  hcr_pkg::t_hrn_ctl                      i_ctl,
    input  logic signed [hcr_pkg::SAMPLE_BITS-1:0] i_h0,
    input  logic signed [hcr_pkg::SAMPLE_BITS-1:0] i_h1,
    input  logic signed [hcr_pkg::SAMPLE_BITS-1:0] i_h2,
    input  logic signed [hcr_pkg::SAMPLE_BITS-1:0] i_x,
    input  logic [hcr_pkg::FRAC_BITS-1:0]          i_phase,
    output hcr_pkg::t_hrn_sts                      o_sts,
    output logic signed [hcr_pkg::SAMPLE_BITS-1:0] o_result
);
    import hcr_pkg::*;

    typedef enum logic [2:0] {
        H_IDLE = 3'b001,
        H_MUL  = 3'b010,
        H_ADD  = 3'b100
    } t_hstate;

    localparam logic signed [ACC_BITS-1:0] SAT_HI = ACC_BITS'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] SAT_LO = -ACC_BITS'(1 << (SAMPLE_BITS - 1));
    localparam logic signed [PROD_BITS-1:0] RND_HALF = PROD_BITS'(1) <<< (FRAC_BITS - 1);

    t_hstate r_state, n_state;
    logic [1:0] r_k, n_k;
    logic r_done, n_done;
    logic signed [ACC_BITS-1:0] r_c3, r_c2, r_c1, r_c0;
    logic signed [ACC_BITS-1:0] r_acc, n_acc;
    logic signed [PROD_BITS-1:0] r_prod;
    logic [FRAC_BITS-1:0] r_p;

    logic signed [ACC_BITS-1:0] h0e, h1e, h2e, xe, d12;
    logic signed [ACC_BITS-1:0] coef;
    logic signed [PROD_BITS-1:0] acc_ext, p_ext, prod, rnd;
    logic signed [ACC_BITS:0] half_sum;
    logic signed [ACC_BITS-1:0] q;

    assign h0e = ACC_BITS'(i_h0);
    assign h1e = ACC_BITS'(i_h1);
    assign h2e = ACC_BITS'(i_h2);
    assign xe  = ACC_BITS'(i_x);
    assign d12 = h1e - h2e;

    assign acc_ext = PROD_BITS'(r_acc);
    assign p_ext   = $signed({{(PROD_BITS-FRAC_BITS){1'b0}}, r_p});
    assign prod    = acc_ext * p_ext;
    assign rnd     = r_prod + RND_HALF;

    always_comb begin
        case (r_k)
            2'd0:    coef = r_c2;
            2'd1:    coef = r_c1;
            default: coef = r_c0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_acc   = r_acc;
        n_done  = 1'b0;
        case (r_state)
            H_IDLE: begin
                if (i_ctl.start) begin
                    n_acc   = r_c3;
                    n_k     = 2'd0;
                    n_state = H_MUL;
                end
            end
            H_MUL: begin
                n_state = H_ADD;
            end
            H_ADD: begin
                n_acc = rnd[FRAC_BITS +: ACC_BITS] + coef;
                if (r_k == 2'd2) begin
                    n_done  = 1'b1;
                    n_state = H_IDLE;
                end else begin
                    n_k     = r_k + 2'd1;
                    n_state = H_MUL;
                end
            end
            default: n_state = H_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= H_IDLE;
            r_done  <= 1'b0;
            r_k     <= 2'd0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
            r_k     <= n_k;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_prod <= prod;
        if (i_ctl.start && r_state == H_IDLE) begin
            r_p <= i_phase;
        end
        // coefficients held doubled so that they stay integer
        if (i_ctl.load) begin
            r_c3 <= (xe - h0e) + (d12 <<< 1) + d12;
            r_c2 <= (h0e <<< 1) - (h1e <<< 2) - h1e + (h2e <<< 2) - xe;
            r_c1 <= h2e - h0e;
            r_c0 <= h1e <<< 1;
        end
    end

    // undo the doubling with round half up, then saturate
    assign half_sum = {r_acc[ACC_BITS-1], r_acc} + (ACC_BITS+1)'(1);
    assign q        = half_sum[ACC_BITS:1];

    always_comb begin
        if (q > SAT_HI) begin
            o_result = SAMPLE_BITS'(SAT_HI);
        end else if (q < SAT_LO) begin
            o_result = SAMPLE_BITS'(SAT_LO);
        end else begin
            o_result = q[SAMPLE_BITS-1:0];
        end
    end

    assign o_sts.busy = (r_state != H_IDLE);
    assign o_sts.done = r_done;
endmodule

// ===== src/hermite_cubic_resampler_unit.sv =====
// hermite_cubic_resampler_unit: top level, sequencer, history memory and output register
// depends on hcr_pkg, hcr_in_if, hcr_out_if, hcr_ram, hcr_horner
//
// Streams interleaved samples, one per transfer, and emits zero to sixteen
// interpolated results per sample through a registered output. History rows
// (three samples per channel) sit in a small ram read and written once per
// sample; per-row valid bits make the history read as zero after reset or a
// channel count change. One sample is processed at a time: each result runs
// three multiply and round steps on one shared multiplier plus handoff and
// emit steps, a bypass sample skips the multiplier, and output stalls hold
// the sample longer.
// Configuration writes are taken at any time but must only be issued while idle.
module hermite_cubic_resampler_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    hcr_in_if.sink                              i_smp,
    hcr_out_if.source                           o_res,
    input  logic                                i_cfg_we,
    input  logic [hcr_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [hcr_pkg::CFG_BITS-1:0]        i_cfg_data
);
    import hcr_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_READ = 7'b0000010,
        S_EVAL = 7'b0000100,
        S_WAIT = 7'b0001000,
        S_EMIT = 7'b0010000,
        S_WB   = 7'b0100000,
        S_SPARE = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [STEP_BITS-1:0] r_step;
    logic                 r_bypass;
    logic [CNT_BITS-1:0]  r_chan_cnt;
    logic [STEP_BITS-1:0] r_phase, n_phase;
    logic [CH_BITS-1:0]   r_ch, n_ch;
    logic [MAX_CHANNELS-1:0] r_row_valid;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [ROW_BITS-1:0]  r_row;
    // one bit wider than the step so that a phase plus a large step cannot wrap
    logic [STEP_BITS:0]   r_p, n_p;

    logic                          r_out_valid, n_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_out_sample, n_out_sample;
    logic [CH_BITS-1:0]            r_out_channel, n_out_channel;
    logic                          r_out_last, n_out_last;

    logic                 accept, out_free, emit_now, frame_end, last_res;
    logic [STEP_BITS-1:0] eff_step;
    logic [STEP_BITS:0]   p_next;
    logic [ROW_BITS-1:0]  rd_row, hist_row;
    logic                 ram_we;
    logic [ROW_BITS-1:0]  wr_row;
    t_hrn_ctl             hrn_ctl;
    t_hrn_sts             hrn_sts;
    logic signed [SAMPLE_BITS-1:0] hrn_result;
    logic                 cfg_cnt_change;
    logic [CNT_BITS-1:0]  cfg_cnt_new;

    assign accept   = i_smp.valid && i_smp.ready;
    assign i_smp.ready = (r_state == S_IDLE);
    assign eff_step = (r_step < MIN_STEP) ? MIN_STEP : r_step;
    assign p_next   = r_p + (STEP_BITS+1)'(eff_step);
    assign last_res = r_bypass || (p_next >= (STEP_BITS+1)'(PHASE_ONE));
    assign out_free = !r_out_valid || o_res.ready;
    assign emit_now = (r_state == S_EMIT) && out_free;
    assign frame_end = ({1'b0, r_ch} + CNT_BITS'(1)) >= eff_channels(r_chan_cnt);

    // a row never written since reset or a count change reads as zero
    assign hist_row = r_row_valid[r_ch] ? rd_row : '0;
    assign wr_row   = {r_x, r_row[ROW_BITS-1 -: SAMPLE_BITS],
                       r_row[SAMPLE_BITS +: SAMPLE_BITS]};
    assign ram_we   = (r_state == S_WB);

    assign cfg_cnt_new    = i_cfg_data[CNT_BITS-1:0];
    assign cfg_cnt_change = i_cfg_we && (i_cfg_idx == REG_CHANNEL_COUNT) &&
                            (eff_channels(cfg_cnt_new) != eff_channels(r_chan_cnt));

    hcr_ram #(
        .WIDTH (ROW_BITS),
        .DEPTH (MAX_CHANNELS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_ch),
        .i_wdata (wr_row),
        .i_re    (accept),
        .i_raddr (r_ch),
        .o_rdata (rd_row)
    );

    assign hrn_ctl.load  = (r_state == S_READ);
    assign hrn_ctl.start = (r_state == S_EVAL);

    hcr_horner u_horner (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (hrn_ctl),
        .i_h0     (hist_row[SAMPLE_BITS-1:0]),
        .i_h1     (hist_row[SAMPLE_BITS +: SAMPLE_BITS]),
        .i_h2     (hist_row[ROW_BITS-1 -: SAMPLE_BITS]),
        .i_x      (r_x),
        .i_phase  (r_p[FRAC_BITS-1:0]),
        .o_sts    (hrn_sts),
        .o_result (hrn_result)
    );

    always_comb begin
        n_state = r_state;
        n_p     = r_p;
        n_phase = r_phase;
        n_ch    = r_ch;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_p = (STEP_BITS+1)'(r_phase);
                if (r_bypass) begin
                    n_state = S_EMIT;
                end else if (r_phase < PHASE_ONE) begin
                    n_state = S_EVAL;
                end else begin
                    n_state = S_WB;
                end
            end
            S_EVAL: begin
                n_state = S_WAIT;
            end
            S_WAIT: begin
                if (hrn_sts.done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (out_free) begin
                    n_p     = p_next;
                    n_state = last_res ? S_WB : S_EVAL;
                end
            end
            S_WB: begin
                if (r_bypass) begin
                    n_phase = '0;
                end else if (frame_end) begin
                    // r_p now holds the first phase at or past one frame
                    n_phase = STEP_BITS'(r_p - (STEP_BITS+1)'(PHASE_ONE));
                end
                n_ch    = frame_end ? '0 : r_ch + CH_BITS'(1);
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid   = r_out_valid;
        n_out_sample  = r_out_sample;
        n_out_channel = r_out_channel;
        n_out_last    = r_out_last;
        if (emit_now) begin
            n_out_valid   = 1'b1;
            n_out_sample  = r_bypass ? r_x : hrn_result;
            n_out_channel = r_ch;
            n_out_last    = last_res;
        end else if (o_res.ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= RST_STEP_RATIO;
            r_bypass    <= 1'b1;
            r_chan_cnt  <= RST_CHANNEL_COUNT;
            r_phase     <= '0;
            r_ch        <= '0;
            r_row_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (cfg_cnt_change) begin
                r_row_valid <= '0;
            end else if (ram_we) begin
                r_row_valid[r_ch] <= 1'b1;
            end
            r_ch <= cfg_cnt_change ? '0 : n_ch;
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_STEP_RATIO:    r_step     <= i_cfg_data[STEP_BITS-1:0];
                    REG_BYPASS:        r_bypass   <= i_cfg_data[0];
                    REG_CHANNEL_COUNT: r_chan_cnt <= cfg_cnt_new;
                    default:           ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_p           <= n_p;
        r_out_sample  <= n_out_sample;
        r_out_channel <= n_out_channel;
        r_out_last    <= n_out_last;
        if (accept) begin
            r_x <= i_smp.in_sample;
        end
        if (r_state == S_READ) begin
            r_row <= hist_row;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.out_sample  = r_out_sample;
    assign o_res.out_channel = r_out_channel;
    assign o_res.last_of_run = r_out_last;
endmodule

// ===== src/hcr_checker.sv =====
// hcr_checker: port level assertions for the resampler, bound to the top level
// depends on hcr_pkg and hermite_cubic_resampler_unit
module hcr_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            i_in_valid,
    input logic                            i_in_ready,
    input logic                            i_out_valid,
    input logic                            i_out_ready,
    input logic [hcr_pkg::SAMPLE_BITS-1:0] i_out_sample,
    input logic [hcr_pkg::CH_BITS-1:0]     i_out_channel,
    input logic                            i_out_last
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_sample) &&
        $stable(i_out_channel) && $stable(i_out_last))
        else $error("stalled result changed");

    // one sample at a time: no new transfer in the cycle after one
    a_one_at_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready right after a transfer");

    // while a run is unfinished no input is taken
    a_run_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_last |-> !i_in_ready)
        else $error("input ready during an open run");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");
endmodule

bind hermite_cubic_resampler_unit hcr_checker u_hcr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_smp.valid),
    .i_in_ready    (i_smp.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_sample  (o_res.out_sample),
    .i_out_channel (o_res.out_channel),
    .i_out_last    (o_res.last_of_run)
);

// ===== verif/testbench.sv =====
// testbench: self-checking bench for hermite_cubic_resampler_unit
// depends on hcr_pkg, hcr_in_if, hcr_out_if and the block; a directed table, then phases
// of random samples, all checked against a behavioural model of the resampler kept in this file
`timescale 1ns / 1ps

module testbench;
    import hcr_pkg::*;

    localparam int LIMIT_CYCLES = 600000;
    localparam int DRAIN_CYCLES = 160;
    localparam int HOLD_CYCLES  = 400;
    localparam logic [CFG_IDX_BITS-1:0] REG_UNUSED = CFG_IDX_BITS'(7);

    typedef struct {
        logic signed [SAMPLE_BITS-1:0] smp;
        logic [CH_BITS-1:0]            ch;
        logic                          last;
    } t_res;

    typedef enum {ROW_CFG, ROW_SMP} t_row_kind;
    typedef struct {
        t_row_kind               kind;
        logic [CFG_IDX_BITS-1:0] idx;
        int                      val;
        bit                      lit;  // sample passes through unchanged
    } t_row;

    typedef struct {
        int unsigned step;
        bit          byp;
        int unsigned chans;
        int          n;
    } t_phase;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] i_cfg_idx = '0;
    logic [CFG_BITS-1:0] i_cfg_data = '0;

    hcr_in_if  smp_if ();
    hcr_out_if res_if ();

    hermite_cubic_resampler_unit uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_smp      (smp_if.sink),
        .o_res      (res_if.source),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // resampler model state
    int unsigned m_step, m_byp, m_chans, m_phase, m_chpos;
    longint      m_hist[MAX_CHANNELS][HISTORY_TAPS];

    t_res pending_res[$];
    int   n_errors = 0;
    int   n_samples = 0;
    int   n_results = 0;
    int   cycles = 0;
    bit   quiet = 1'b0;
    bit   hold_done = 1'b0;
    int   hold_cnt = 0;
    int   stall_left = 0;

    function automatic int unsigned chans_of(int unsigned v);
        if (v == 0) return 1;
        if (v > MAX_CHANNELS) return MAX_CHANNELS;
        return v;
    endfunction

    function automatic longint rnd(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint interp(longint h0, longint h1, longint h2, longint x,
                                      longint p);
        longint c3, c2, c1, c0, a;
        c3 = x - h0 + 3 * (h1 - h2);
        c2 = 2 * h0 - 5 * h1 + 4 * h2 - x;
        c1 = h2 - h0;
        c0 = 2 * h1;
        a = rnd(c3 * p, FRAC_BITS) + c2;
        a = rnd(a * p, FRAC_BITS) + c1;
        a = rnd(a * p, FRAC_BITS) + c0;
        a = rnd(a, 1);
        if (a > 8388607) a = 8388607;
        if (a < -8388608) a = -8388608;
        return a;
    endfunction

    task automatic model_reset();
        m_step = 1 << FRAC_BITS;
        m_byp = 1;
        m_chans = 1;
        m_phase = 0;
        m_chpos = 0;
        foreach (m_hist[c, t]) m_hist[c][t] = 0;
    endtask

    task automatic model_write(logic [CFG_IDX_BITS-1:0] idx, int unsigned v);
        case (idx)
            REG_STEP_RATIO: m_step = v & 32'hFFFFF;
            REG_BYPASS:     m_byp = v & 1;
            REG_CHANNEL_COUNT: begin
                if (chans_of(v & 4'hF) != chans_of(m_chans)) begin
                    foreach (m_hist[c, t]) m_hist[c][t] = 0;
                    m_chpos = 0;
                end
                m_chans = v & 4'hF;
            end
            default: ;
        endcase
    endtask

    // works out the results of one accepted sample and queues them
    task automatic resample(logic signed [SAMPLE_BITS-1:0] x_in, bit lit);
        int unsigned one, st, p, slot;
        int          n;
        longint      x;
        t_res        r;
        one = 1 << FRAC_BITS;
        st = (m_step < MIN_STEP) ? MIN_STEP : m_step;
        slot = (m_chpos < MAX_CHANNELS) ? m_chpos : MAX_CHANNELS - 1;
        x = x_in;
        n = 0;
        if (m_byp != 0) begin
            r.smp = lit ? x_in : SAMPLE_BITS'(x);
            r.ch = CH_BITS'(m_chpos);
            r.last = 1'b1;
            pending_res.push_back(r);
            m_phase = 0;
        end else begin
            p = m_phase;
            while (p < one && n < MAX_OUT) begin
                r.smp = SAMPLE_BITS'(interp(m_hist[slot][0], m_hist[slot][1],
                                            m_hist[slot][2], x, p));
                r.ch = CH_BITS'(m_chpos);
                r.last = 1'b0;
                pending_res.push_back(r);
                n++;
                p += st;
            end
            if (n > 0) pending_res[$].last = 1'b1;
        end
        m_hist[slot][0] = m_hist[slot][1];
        m_hist[slot][1] = m_hist[slot][2];
        m_hist[slot][2] = x;
        m_chpos++;
        if (m_chpos >= chans_of(m_chans)) begin
            m_chpos = 0;
            if (m_byp == 0) begin
                p = m_phase;
                while (p < one) p += st;
                m_phase = p - one;
            end
        end
    endtask

    task automatic send_sample(logic signed [SAMPLE_BITS-1:0] x, bit lit);
        if (!quiet && $urandom_range(0, 3) == 0) begin
            smp_if.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        smp_if.valid <= 1'b1;
        smp_if.in_sample <= x;
        @(posedge i_clk);
        while (!smp_if.ready) @(posedge i_clk);
        n_samples++;
        resample(x, lit);
    endtask

    // waits for every expected result, then lets a sample with no result finish
    task automatic drain();
        smp_if.valid <= 1'b0;
        while (pending_res.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, int unsigned v);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= CFG_BITS'(v);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        model_write(idx, v);
    endtask

    function automatic logic signed [SAMPLE_BITS-1:0] pick_sample(
            logic signed [SAMPLE_BITS-1:0] prev);
        case ($urandom_range(0, 3))
            0: return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
            1: return prev + SAMPLE_BITS'($urandom_range(0, 4000)) - 24'sd2000;
            default: return SAMPLE_BITS'($urandom());
        endcase
    endfunction

    // receiver: random stalls, a long hold-off once the output has got going
    always @(posedge i_clk) begin
        if (res_if.valid && res_if.ready) begin
            if (pending_res.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: sample %0d channel %0d last %0b",
                             res_if.out_sample, res_if.out_channel, res_if.last_of_run);
            end else begin
                t_res e;
                e = pending_res.pop_front();
                n_results++;
                if (e.smp !== res_if.out_sample || e.ch !== res_if.out_channel ||
                    e.last !== res_if.last_of_run) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch at result %0d: expected %0d/%0d/%0b got %0d/%0d/%0b",
                                 n_results, e.smp, e.ch, e.last, res_if.out_sample,
                                 res_if.out_channel, res_if.last_of_run);
                end
            end
        end
        if (hold_cnt != 0) begin
            res_if.ready <= 1'b0;
        end else if (stall_left != 0) begin
            res_if.ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            res_if.ready <= 1'b0;
            stall_left <= $urandom_range(0, 2);
        end else begin
            res_if.ready <= i_rst_n;
        end
    end

    always @(posedge i_clk) begin
        if (!hold_done && n_results >= 120) begin
            hold_done <= 1'b1;
            hold_cnt <= HOLD_CYCLES;
        end else if (hold_cnt != 0) begin
            hold_cnt <= hold_cnt - 1;
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES) begin
            $display("timeout after %0d cycles", cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    t_row dir_rows[$] = '{
        '{ROW_SMP, REG_STEP_RATIO, 0, 1},
        '{ROW_SMP, REG_STEP_RATIO, 8388607, 1},
        '{ROW_SMP, REG_STEP_RATIO, -8388608, 1},
        '{ROW_SMP, REG_STEP_RATIO, 1, 1},
        '{ROW_SMP, REG_STEP_RATIO, -1, 1},
        '{ROW_SMP, REG_STEP_RATIO, 2796202, 1},
        '{ROW_CFG, REG_BYPASS, 0, 0},
        '{ROW_CFG, REG_STEP_RATIO, 65536, 0},
        '{ROW_SMP, REG_STEP_RATIO, 8388607, 0},
        '{ROW_SMP, REG_STEP_RATIO, -8388608, 0},
        '{ROW_SMP, REG_STEP_RATIO, 8388607, 0},
        '{ROW_SMP, REG_STEP_RATIO, -8388608, 0},
        '{ROW_SMP, REG_STEP_RATIO, 1000, 0},
        '{ROW_CFG, REG_STEP_RATIO, 100, 0},       // below the minimum step
        '{ROW_SMP, REG_STEP_RATIO, 5000, 0},
        '{ROW_SMP, REG_STEP_RATIO, -7000, 0},
        '{ROW_CFG, REG_STEP_RATIO, 1048575, 0},   // phase jumps past a frame
        '{ROW_SMP, REG_STEP_RATIO, 3, 0},
        '{ROW_SMP, REG_STEP_RATIO, 4, 0},
        '{ROW_SMP, REG_STEP_RATIO, 5, 0},
        '{ROW_CFG, REG_UNUSED, 12345, 0},
        '{ROW_CFG, REG_CHANNEL_COUNT, 0, 0},
        '{ROW_CFG, REG_CHANNEL_COUNT, 15, 0},
        '{ROW_SMP, REG_STEP_RATIO, 11, 0},
        '{ROW_SMP, REG_STEP_RATIO, -12, 0}
    };

    t_phase phases[$] = '{
        '{65536, 0, 1, 10},
        '{40000, 0, 2, 6},
        '{4096, 0, 3, 4},
        '{524288, 0, 1, 10},
        '{98304, 0, 8, 3},
        '{65536, 1, 4, 3},
        '{30000, 0, 1, 12}
    };

    initial begin
        logic signed [SAMPLE_BITS-1:0] x;
        smp_if.valid = 1'b0;
        smp_if.in_sample = '0;
        res_if.ready = 1'b0;
        model_reset();
        x = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[i]) begin
            if (dir_rows[i].kind == ROW_CFG) begin
                drain();
                write_reg(dir_rows[i].idx, dir_rows[i].val);
            end else begin
                send_sample(SAMPLE_BITS'(dir_rows[i].val), dir_rows[i].lit);
            end
        end

        foreach (phases[k]) begin
            drain();
            if (k == phases.size() - 1) quiet = 1'b1;
            write_reg(REG_STEP_RATIO, phases[k].step);
            write_reg(REG_BYPASS, phases[k].byp);
            write_reg(REG_CHANNEL_COUNT, phases[k].chans);
            for (int j = 0; j < phases[k].n; j++) begin
                // whole frames keep the phase moving between channels
                for (int c = 0; c < chans_of(phases[k].chans); c++) begin
                    x = pick_sample(x);
                    send_sample(x, 1'b0);
                end
            end
        end
        drain();

        if (pending_res.size() != 0) n_errors++;
        $display("%0d samples sent, %0d results checked, %0d mismatches",
                 n_samples, n_results, n_errors);
        $display("covered bypass, clamped and oversized steps, 1 to 8 channels, saturation");
        if (n_errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
